// ===== hdl/scmr_pkg.sv =====
`default_nettype none
package scmr_pkg;
  localparam int unsigned SampleW = 16;
  localparam int unsigned MeanW = 24;
  localparam int unsigned RmsW = 25;
  localparam int unsigned VarW = 40;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned DefMaxSamples = 4096;
  localparam logic [RmsW-1:0] ZeroRmsCode = 25'd25600000;
  localparam logic [VarW-1:0] VarSat = {VarW{1'b1}};

  localparam logic [CfgIdxW-1:0] RegClipEnable = 2'd0;
  localparam logic [CfgIdxW-1:0] RegClipFactor = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMaxIter = 2'd2;
  localparam logic [CfgIdxW-1:0] RegTolerance = 2'd3;

  // Request and answer of the shared sequential divider.
  typedef struct packed {
    logic        start;
    logic [95:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [95:0] quo;
    logic [63:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] value;
  } sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } sqrt_rsp_t;
endpackage
`default_nettype wire

// ===== hdl/scmr_div.sv =====
`default_nettype none
module scmr_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire scmr_pkg::div_req_t req_i,
  output scmr_pkg::div_rsp_t      rsp_o
);
  import scmr_pkg::*;

  // Restoring division, one quotient bit per cycle.
  logic [95:0] quo_q, quo_d;
  logic [64:0] rem_q, rem_d;
  logic [63:0] den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [64:0] trial;
  logic [64:0] shifted;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    shifted = {rem_q[63:0], quo_q[95]};
    trial = shifted - {1'b0, den_q};
    if (req_i.start) begin
      quo_d = req_i.num;
      rem_d = '0;
      den_d = req_i.den;
      cnt_d = 7'd96;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_d = trial;
        quo_d = {quo_q[94:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[94:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo = quo_q;
  assign rsp_o.rem = rem_q[63:0];

`ifndef SYNTH
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done held");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without work");
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> cnt_q == 7'd0 || $past(busy_q)) else $error("divider count");
`endif
endmodule
`default_nettype wire

// ===== hdl/scmr_sqrt.sv =====
`default_nettype none
module scmr_sqrt (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire scmr_pkg::sqrt_req_t req_i,
  output scmr_pkg::sqrt_rsp_t      rsp_o
);
  import scmr_pkg::*;

  // Digit-by-digit floor root, one result bit per cycle.
  logic [63:0] val_q, val_d;
  logic [63:0] res_q, res_d;
  logic [63:0] bit_q, bit_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [63:0] cand;

  always_comb begin
    val_d = val_q;
    res_d = res_q;
    bit_d = bit_q;
    busy_d = busy_q;
    done_d = 1'b0;
    cand = res_q + bit_q;
    if (req_i.start) begin
      val_d = req_i.value;
      res_d = '0;
      bit_d = 64'h4000_0000_0000_0000;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (val_q >= cand) begin
        val_d = val_q - cand;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = res_q[31:0];

`ifndef SYNTH
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("root done held");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("root done without work");
  a_root_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> res_q[63:32] == 32'd0) else $error("root too wide");
`endif
endmodule
`default_nettype wire

// ===== hdl/sigma_clipped_mean_rms.sv =====
`default_nettype none
// A beat without the last flag is taken and gives no result. A last beat starts
// the plain statistics, and each clipping pass adds a mean sweep and a deviation
// sweep over the n samples, two 96-step divisions, a 32-step root and bookkeeping.
// The block takes no new samples while busy; the one-cycle result strobe follows
// and the receiver cannot stall it. Reset clears the sequencer state and sums and
// loads the configuration defaults; the sample memory and results are not reset.
module sigma_clipped_mean_rms #(
  parameter int unsigned MAX_SAMPLES = scmr_pkg::DefMaxSamples
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [scmr_pkg::SampleW-1:0] sample_i,
  input  wire logic                          last_sample_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [scmr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [scmr_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                               strobe,
  output logic signed [scmr_pkg::MeanW-1:0]  mean_value_o,
  output logic [scmr_pkg::RmsW-1:0]          rms_value_o,
  output logic [scmr_pkg::VarW-1:0]          variance_value_o,
  output logic                               zero_rms_o,
  output logic                               too_few_samples_o
);
  import scmr_pkg::*;

  localparam int unsigned AddrW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1);

  // Sequencer states. Each clipping pass runs a mean sweep, a mean division,
  // a deviation sweep, a variance division and a root.
  typedef enum logic [4:0] {
    S_LOAD, S_V_MUL1, S_V_MUL2, S_V_DIV, S_V_SQRT, S_M_DIV,
    S_P_INIT, S_P_SWEEP_M, S_P_MDIV, S_P_INIT2, S_P_SWEEP_R, S_P_RDIV,
    S_P_SQRT, S_P_CHECK, S_DONE
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic       clip_en_q;
  logic [7:0] clip_factor_q;
  logic [4:0] max_iter_q;
  logic [7:0] tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_en_q <= 1'b1;
      clip_factor_q <= 8'd64;
      max_iter_q <= 5'd10;
      tol_q <= 8'd13;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegClipEnable: clip_en_q <= cfg_data_i[0];
        RegClipFactor: clip_factor_q <= cfg_data_i;
        RegMaxIter:    max_iter_q <= cfg_data_i[4:0];
        RegTolerance:  tol_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sample memory with a registered read port.
  logic signed [SampleW-1:0] mem_q [MAX_SAMPLES];
  logic signed [SampleW-1:0] rd_q;
  logic [AddrW-1:0] rd_addr;
  logic             mem_we;

  logic [CntW-1:0]    cnt_q;
  logic signed [39:0] sum_q;
  logic [63:0]        sq_q;
  logic [CntW-1:0]    idx_q;
  logic               rvalid_q;
  logic [CntW-1:0]    kept_q;
  logic signed [63:0] psum_q;
  logic [63:0]        psq_q;
  logic signed [24:0] mean_q;
  logic [24:0]        rms_q, prev_q;
  logic [4:0]         it_q;
  logic [39:0]        var_q;
  logic               few_q, zero_q;
  logic [63:0]        t_q;
  logic [63:0]        lim_q;
  logic [63:0]        dev_q;
  logic               dvalid_q;
  logic               neg_q;
  logic [95:0]        num_q;
  logic [63:0]        den_q;
  logic               issue_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[cnt_q[AddrW-1:0]] <= sample_i;
    rd_q <= mem_q[rd_addr];
  end

  assign mem_we = (state_q == S_LOAD) && start && (cnt_q < CntW'(MAX_SAMPLES));
  assign rd_addr = idx_q[AddrW-1:0];
  assign busy = (state_q != S_LOAD);

  div_req_t  div_req;
  div_rsp_t  div_rsp;
  sqrt_req_t sq_req;
  sqrt_rsp_t sq_rsp;

  scmr_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(div_req), .rsp_o(div_rsp));
  scmr_sqrt u_sqrt (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(sq_req), .rsp_o(sq_rsp));

  // Variance numerator terms: n*sq from two narrow products, and |sum|^2.
  logic [CntW+31:0]  nsq_lo, nsq_hi;
  logic [31:0]       sum_mag;
  logic [63:0]       sum_sqr;
  logic [2*CntW-1:0] nn1;
  assign nsq_lo = cnt_q * sq_q[31:0];
  assign nsq_hi = cnt_q * sq_q[63:32];
  assign sum_mag = sum_q[39] ? 32'(-sum_q) : 32'(sum_q);
  assign sum_sqr = sum_mag * sum_mag;
  assign nn1 = cnt_q * (cnt_q - CntW'(1));

  // Deviation of the read sample from the reference mean, q8.
  logic signed [25:0] dev_s;
  logic [25:0]        dev_abs;
  assign dev_s = 26'(signed'({rd_q, 8'd0})) - 26'(mean_q);
  assign dev_abs = dev_s[25] ? 26'(-dev_s) : dev_s;

  // Rounded mean from a quotient; sign handled on magnitudes.
  logic [95:0] rmean;
  assign rmean = neg_q ? (div_rsp.rem != 64'd0 ? div_rsp.quo + 96'd1 : div_rsp.quo)
                       : div_rsp.quo;

  logic [63:0] change;
  assign change = (prev_q > rms_q) ? 64'(prev_q - rms_q) : 64'(rms_q - prev_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q <= '0;
      strobe <= 1'b0;
      issue_q <= 1'b0;
      rvalid_q <= 1'b0;
      dvalid_q <= 1'b0;
      sum_q <= '0;
      sq_q <= '0;
      idx_q <= '0;
    end else begin
      strobe <= 1'b0;
      issue_q <= 1'b0;
      rvalid_q <= 1'b0;
      dvalid_q <= 1'b0;
      unique case (state_q)
        S_LOAD: begin
          if (start) begin
            if (mem_we) begin
              cnt_q <= cnt_q + CntW'(1);
              sum_q <= sum_q + 40'(sample_i);
              sq_q <= sq_q + 64'(33'(sample_i * sample_i));
            end
            if (last_sample_i) state_q <= S_V_MUL1;
          end
        end
        S_V_MUL1: begin
          // n*sq and sum^2, split into cycles
          few_q <= cnt_q < CntW'(2);
          t_q <= 64'(nsq_lo) + {nsq_hi[31:0], 32'd0};
          neg_q <= sum_q[39];
          state_q <= S_V_MUL2;
        end
        S_V_MUL2: begin
          t_q <= t_q - sum_sqr;
          den_q <= 64'(nn1);
          issue_q <= 1'b1;
          state_q <= S_V_DIV;
        end
        S_V_DIV: begin
          if (few_q) begin
            var_q <= '0;
            issue_q <= 1'b1;
            state_q <= S_V_SQRT;
          end else if (div_rsp.done) begin
            if (div_rsp.quo[95:40] != 56'd0) var_q <= VarSat;
            else var_q <= div_rsp.quo[39:0];
            issue_q <= 1'b1;
            state_q <= S_V_SQRT;
          end
        end
        S_V_SQRT: begin
          if (sq_rsp.done) begin
            rms_q <= sq_rsp.root[24:0];
            issue_q <= 1'b1;
            kept_q <= cnt_q;
            psum_q <= 64'(sum_q);
            state_q <= S_M_DIV;
          end
        end
        S_M_DIV: begin
          if (div_rsp.done) begin
            mean_q <= neg_q ? 25'(-rmean) : 25'(rmean);
            it_q <= 5'd1;
            zero_q <= 1'b0;
            state_q <= (clip_en_q && !few_q && max_iter_q > 5'd1) ? S_P_INIT : S_DONE;
          end
        end
        S_P_INIT: begin
          lim_q <= 64'(clip_factor_q) * 64'(rms_q);
          idx_q <= '0;
          kept_q <= '0;
          psum_q <= '0;
          rvalid_q <= 1'b0;
          state_q <= S_P_SWEEP_M;
        end
        S_P_SWEEP_M: begin
          if (idx_q < cnt_q) begin
            idx_q <= idx_q + CntW'(1);
            rvalid_q <= 1'b1;
          end
          if (rvalid_q && (64'(dev_abs) << 4) <= lim_q) begin
            kept_q <= kept_q + CntW'(1);
            psum_q <= psum_q + 64'(rd_q);
          end
          if (!rvalid_q && idx_q == cnt_q && idx_q != '0) begin
            neg_q <= psum_q[63];
            issue_q <= (kept_q != '0);
            state_q <= S_P_MDIV;
          end
        end
        S_P_MDIV: begin
          if (kept_q == '0) begin
            mean_q <= '0;
            state_q <= S_P_INIT2;
          end else if (div_rsp.done) begin
            mean_q <= neg_q ? 25'(-rmean) : 25'(rmean);
            state_q <= S_P_INIT2;
          end
        end
        S_P_INIT2: begin
          prev_q <= rms_q;
          idx_q <= '0;
          kept_q <= '0;
          psq_q <= '0;
          state_q <= S_P_SWEEP_R;
        end
        S_P_SWEEP_R: begin
          if (idx_q < cnt_q) begin
            idx_q <= idx_q + CntW'(1);
            rvalid_q <= 1'b1;
          end
          // stage the deviation in dev_q, then square the registered value
          dev_q <= 64'(dev_abs);
          dvalid_q <= rvalid_q && (64'(dev_abs) << 4) <= lim_q;
          if (dvalid_q) begin
            kept_q <= kept_q + CntW'(1);
            psq_q <= psq_q + dev_q[31:0] * dev_q[31:0];
          end
          if (!rvalid_q && !dvalid_q && idx_q == cnt_q && idx_q != '0) begin
            issue_q <= (kept_q != '0);
            state_q <= S_P_RDIV;
          end
        end
        S_P_RDIV: begin
          if (kept_q == '0) begin
            rms_q <= '0;
            state_q <= S_P_CHECK;
          end else if (div_rsp.done) begin
            t_q <= div_rsp.quo[63:0];
            issue_q <= 1'b1;
            state_q <= S_P_SQRT;
          end
        end
        S_P_SQRT: begin
          if (sq_rsp.done) begin
            rms_q <= sq_rsp.root[24:0];
            state_q <= S_P_CHECK;
          end
        end
        S_P_CHECK: begin
          if (rms_q == '0) begin
            zero_q <= 1'b1;
            state_q <= S_DONE;
          end else if ((change << 8) < 64'(tol_q) * 64'(rms_q)) begin
            state_q <= S_DONE;
          end else if (it_q + 5'd1 >= max_iter_q) begin
            state_q <= S_DONE;
          end else begin
            it_q <= it_q + 5'd1;
            state_q <= S_P_INIT;
          end
        end
        S_DONE: begin
          strobe <= 1'b1;
          mean_value_o <= mean_q[23:0];
          rms_value_o <= zero_q ? ZeroRmsCode : rms_q;
          variance_value_o <= var_q;
          zero_rms_o <= zero_q;
          too_few_samples_o <= few_q;
          cnt_q <= '0;
          sum_q <= '0;
          sq_q <= '0;
          state_q <= S_LOAD;
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  // Operand selection for the shared divider and root.
  logic [63:0] mag;
  always_comb begin
    div_req = '0;
    sq_req = '0;
    mag = '0;
    unique case (state_q)
      S_V_DIV: begin
        div_req.start = issue_q && !few_q;
        div_req.num = 96'({t_q, 8'd0});
        div_req.den = den_q;
      end
      S_M_DIV, S_P_MDIV: begin
        mag = psum_q[63] ? 64'(-psum_q) : 64'(psum_q);
        // round half up on the signed value: |s|*512 -/+ k over 2k; a small
        // negative sum whose |s|*512 does not exceed k rounds to zero
        div_req.start = issue_q;
        if (!psum_q[63]) begin
          div_req.num = 96'({mag, 9'd0}) + 96'(kept_q);
        end else if (96'({mag, 9'd0}) > 96'(kept_q)) begin
          div_req.num = 96'({mag, 9'd0}) - 96'(kept_q);
        end
        div_req.den = 64'(kept_q) << 1;
      end
      S_P_RDIV: begin
        div_req.start = issue_q;
        div_req.num = 96'(psq_q);
        div_req.den = 64'(kept_q);
      end
      S_V_SQRT: begin
        sq_req.start = issue_q;
        sq_req.value = 64'({var_q, 8'd0});
      end
      S_P_SQRT: begin
        sq_req.start = issue_q;
        sq_req.value = t_q;
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_strobe_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe |=> !strobe) else $error("result strobe held");
  a_zero_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && zero_rms_o |-> rms_value_o == ZeroRmsCode) else $error("zero rms code");
  a_few_var: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && too_few_samples_o |-> variance_value_o == '0) else $error("few variance");
`endif
endmodule
`default_nettype wire

// ===== verif/scmr_checker.sv =====
`timescale 1ns / 1ps
// Watches the sample, register and result channels of the sigma-clipped
// statistics block, predicts every result and compares it field by field.
module scmr_checker (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire logic                               busy_i,
  input  wire logic signed [scmr_pkg::SampleW-1:0] sample_i,
  input  wire logic                               last_sample_i,
  input  wire logic                               cfg_we_i,
  input  wire logic [scmr_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [scmr_pkg::CfgDataW-1:0]      cfg_data_i,
  input  wire logic                               strobe_i,
  input  wire logic signed [scmr_pkg::MeanW-1:0]  mean_value_i,
  input  wire logic [scmr_pkg::RmsW-1:0]          rms_value_i,
  input  wire logic [scmr_pkg::VarW-1:0]          variance_value_i,
  input  wire logic                               zero_rms_i,
  input  wire logic                               too_few_samples_i,
  output int                                      errors_o,
  output int                                      pending_o
);
  import scmr_pkg::*;

  localparam int unsigned Depth = DefMaxSamples;

  typedef struct packed {
    logic signed [MeanW-1:0] mean;
    logic [RmsW-1:0]         rms;
    logic [VarW-1:0]         variance;
    logic                    zero_rms;
    logic                    too_few;
  } block_stats_t;

  block_stats_t expected_stats[$];

  logic signed [SampleW-1:0] block_samples[Depth];
  int unsigned               block_len;
  longint                    block_sum;
  longint unsigned           block_sq;

  logic       clip_on;
  logic [7:0] clip_mult;
  logic [4:0] iter_limit;
  logic [7:0] tol;

  int errors;
  int pending;
  assign errors_o  = errors;
  assign pending_o = pending;

  function automatic longint unsigned isqrt_floor(longint unsigned v);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v = v - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  // Rounded q8 mean, halves toward plus infinity.
  function automatic longint round_mean_q8(longint s, longint k);
    longint num, den;
    num = s * 512 + k;
    den = 2 * k;
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  function automatic longint unsigned dev_q8(longint x, longint m);
    longint d;
    d = x * 256 - m;
    return (d < 0) ? longint'(-d) : longint'(d);
  endfunction

  // Works out the statistics of the collected block.
  function automatic block_stats_t compute_block_stats();
    block_stats_t    res;
    longint unsigned n, variance, lim, abs_sum, dn, den, sq, d, ch, rms, prev_rms;
    longint          mean, mean0, s;
    longint unsigned kept;
    logic            zero, few;
    n = block_len;
    few = (n < 2);
    zero = 0;
    mean = round_mean_q8(block_sum, longint'(n));
    variance = 0;
    if (!few) begin
      abs_sum = (block_sum < 0) ? longint'(-block_sum) : longint'(block_sum);
      dn = n * block_sq - abs_sum * abs_sum;
      den = n * (n - 1);
      variance = (dn / den) * 256 + ((dn % den) * 256) / den;
      if (variance > 64'hFF_FFFF_FFFF) variance = 64'hFF_FFFF_FFFF;
    end
    rms = isqrt_floor(variance * 256);
    if (clip_on && !few) begin
      for (int unsigned it = 1; it < iter_limit; it++) begin
        mean0 = mean;
        s = 0;
        sq = 0;
        lim = longint'(clip_mult) * rms;
        kept = 0;
        for (int unsigned i = 0; i < n; i++) begin
          if (dev_q8(block_samples[i], mean0) * 16 <= lim) begin
            s += block_samples[i];
            kept++;
          end
        end
        mean = (kept != 0) ? round_mean_q8(s, longint'(kept)) : 0;
        prev_rms = rms;
        kept = 0;
        for (int unsigned i = 0; i < n; i++) begin
          d = dev_q8(block_samples[i], mean);
          if (d * 16 <= lim) begin
            sq += d * d;
            kept++;
          end
        end
        rms = (kept != 0) ? isqrt_floor(sq / kept) : 0;
        if (rms == 0) begin
          zero = 1;
          break;
        end
        ch = (prev_rms > rms) ? prev_rms - rms : rms - prev_rms;
        if (ch * 256 < longint'(tol) * rms) break;
      end
    end
    res.mean     = mean[MeanW-1:0];
    res.rms      = zero ? ZeroRmsCode : rms[RmsW-1:0];
    res.variance = variance[VarW-1:0];
    res.zero_rms = zero;
    res.too_few  = few;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    block_stats_t exp_s;
    if (!rst_ni) begin
      block_len  = 0;
      block_sum  = 0;
      block_sq   = 0;
      clip_on    = 1'b1;
      clip_mult  = 8'd64;
      iter_limit = 5'd10;
      tol        = 8'd13;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegClipEnable: clip_on    = cfg_data_i[0];
          RegClipFactor: clip_mult  = cfg_data_i;
          RegMaxIter:    iter_limit = cfg_data_i[4:0];
          RegTolerance:  tol        = cfg_data_i;
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        if (block_len < Depth) begin
          block_samples[block_len] = sample_i;
          block_len++;
          block_sum += sample_i;
          block_sq += longint'(sample_i) * longint'(sample_i);
        end
        if (last_sample_i) begin
          expected_stats.push_back(compute_block_stats());
          block_len = 0;
          block_sum = 0;
          block_sq  = 0;
        end
      end
      if (strobe_i) begin
        if (expected_stats.size() == 0) begin
          report_mismatch("unexpected result, mean", mean_value_i, 0);
        end else begin
          exp_s = expected_stats.pop_front();
          if (mean_value_i !== exp_s.mean)
            report_mismatch("mean_value", mean_value_i, exp_s.mean);
          if (rms_value_i !== exp_s.rms)
            report_mismatch("rms_value", rms_value_i, exp_s.rms);
          if (variance_value_i !== exp_s.variance)
            report_mismatch("variance_value", variance_value_i, exp_s.variance);
          if (zero_rms_i !== exp_s.zero_rms)
            report_mismatch("zero_rms", zero_rms_i, exp_s.zero_rms);
          if (too_few_samples_i !== exp_s.too_few)
            report_mismatch("too_few_samples", too_few_samples_i, exp_s.too_few);
        end
      end
      pending = expected_stats.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the sigma-clipped statistics block. The checker
// beside the block does all prediction and comparison.
module tb_top;
  import scmr_pkg::*;

  // Every block may run one clipping pass less than the iteration limit, each with two divisions, so the limit is wide.
  localparam longint CycleLimit = 20000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic signed [SampleW-1:0] sample_i = '0;
  logic last_sample_i = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic busy, strobe, zero_rms_o, too_few_samples_o;
  logic signed [MeanW-1:0] mean_value_o;
  logic [RmsW-1:0] rms_value_o;
  logic [VarW-1:0] variance_value_o;
  int errors, pending;
  longint cycles = 0;

  // Sender burst state: beats left in the current burst and whether gaps run.
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int beats_sent = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sigma_clipped_mean_rms dut (
    .clk_i, .rst_ni, .start, .busy, .sample_i, .last_sample_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .strobe, .mean_value_o,
    .rms_value_o, .variance_value_o, .zero_rms_o, .too_few_samples_o
  );

  scmr_checker u_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .sample_i, .last_sample_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .strobe_i(strobe),
    .mean_value_i(mean_value_o), .rms_value_i(rms_value_o),
    .variance_value_i(variance_value_o), .zero_rms_i(zero_rms_o),
    .too_few_samples_i(too_few_samples_o), .errors_o(errors), .pending_o(pending)
  );

  // A hung block must not hang the run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Drives one sample beat. The task is entered and left at a falling edge,
  // and start stays high when the next beat follows at once.
  task automatic send_beat(int value, bit last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = gaps_on ? $urandom_range(0, 12) : 0;
      if (gap != 0) begin
        start = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    start = 1'b1;
    sample_i = value[SampleW-1:0];
    last_sample_i = last;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    beats_sent++;
    // A last beat leaves the block busy for a long time; drop start meanwhile.
    if (last) start = 1'b0;
  endtask

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Sends a block of n samples. Kinds: noisy cluster with outliers, constant
  // with one outlier, full-range random, and only the two extremes.
  task automatic send_block(int n, int kind);
    int center, amp, v, odd_pos;
    center = $urandom_range(0, 65535) - 32768;
    amp = 1 << $urandom_range(0, 12);
    odd_pos = $urandom_range(0, n - 1);
    for (int i = 0; i < n; i++) begin
      case (kind)
        0: begin
          v = center + $urandom_range(0, 2 * amp) - amp;
          if ($urandom_range(0, 9) == 0) v = center + ($urandom_range(0, 1) ? 8 : -8) * amp;
        end
        1: v = (i == odd_pos) ? center + amp * 16 : center;
        2: v = $urandom_range(0, 65535) - 32768;
        default: v = $urandom_range(0, 1) ? 32767 : -32768;
      endcase
      send_beat(clamp16(v), i == n - 1);
    end
  endtask

  // Waits until every result is in and the block has gone quiet.
  task automatic wait_idle();
    while (pending != 0 || busy) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int value);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = value[CfgDataW-1:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_config(int en, int factor, int iters, int tolv);
    wait_idle();
    write_reg(RegClipEnable, en);
    write_reg(RegClipFactor, factor);
    write_reg(RegMaxIter, iters);
    write_reg(RegTolerance, tolv);
  endtask

  initial begin
    int n, kind, phase;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part under the reset register values.
    send_block(1, 0);                 // a single sample is too few
    send_beat(-32768, 1'b0);
    send_beat(32767, 1'b1);           // both extremes
    send_block(4, 1);                 // constant plus outlier
    for (int i = 0; i < 3; i++) send_beat(-5, i == 2);  // constant block
    send_block(6, 0);
    set_config(0, 64, 10, 13);        // plain statistics only
    send_block(4, 1);
    set_config(1, 64, 1, 13);         // one iteration means no clipping pass
    send_block(4, 1);
    set_config(1, 255, 16, 0);
    send_block(5, 3);

    // Random part: phases with varied registers, extremes among them.
    phase = 0;
    while (beats_sent < 1100) begin
      case (phase % 8)
        0: set_config(1, 64, 10, 13);
        1: set_config(1, 1, 16, 255);
        2: set_config(1, 255, 16, 0);
        3: set_config(0, $urandom_range(1, 255), $urandom_range(1, 16), $urandom_range(0, 255));
        4: set_config(1, $urandom_range(8, 80), 0, $urandom_range(0, 255));
        default: set_config(1, $urandom_range(1, 255), $urandom_range(1, 16),
                            $urandom_range(0, 255));
      endcase
      gaps_on = (phase % 3) != 2;
      for (int b = 0; b < 8; b++) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(2, 24);
        kind = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 3);
        send_block(n, kind);
      end
      phase++;
    end

    wait_idle();
    repeat (500) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
